### hw/rtl/bcs_pkg.sv
// Shared constants and types for the bounded compacting set.
// Used by bcs_ctrl, bcs_datapath and the top level bounded_compacting_set.
`default_nettype none

package bcs_pkg;

  // Storage geometry
  localparam int unsigned Capacity   = 128;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned AddrWidth  = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntWidth   = $clog2(Capacity + 1);

  // Port field widths
  localparam int unsigned FuncWidth  = 2;
  localparam int unsigned InValWidth = 32;
  localparam int unsigned StatWidth  = 2;
  localparam int unsigned OutCntWidth = 8;

  // Operation codes
  typedef enum logic [FuncWidth-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [StatWidth-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;        // capture input word, reset search pointer
    logic search;      // one step of the linear search
    logic shift_init;  // set up compaction after a remove hit
    logic shift;       // one step of the shift-down
    logic finish;      // update count, insert, load output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic search_done;
    logic match;
    logic shift_done;
    logic out_free;
    logic is_remove;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/bcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [Width-1:0]   rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/bcs_ctrl.sv
// Control state machine of the bounded compacting set.
// Depends on bcs_pkg; drives bcs_datapath through cmd_t / sts_t.
`default_nettype none

module bcs_ctrl import bcs_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [FuncWidth-1:0] func_i,
  input  wire sts_t                 sts_i,
  output cmd_t                      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (op_e'(func_i) == OP_CLEAR) ? S_DONE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.search_done) begin
          if (sts_i.match && sts_i.is_remove) begin
            cmd_o.shift_init = 1'b1;
            state_d          = S_SHIFT;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bcs_datapath.sv
// Datapath of the bounded compacting set: entry RAM, fill count, search and
// shift pointers, output register. Depends on bcs_pkg and bcs_ram.
`default_nettype none

module bcs_datapath import bcs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output sts_t                        sts_o,
  input  wire logic [FuncWidth-1:0]   func_i,
  input  wire logic [InValWidth-1:0]  value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        found_o,
  output logic [StatWidth-1:0]        status_o,
  output logic [OutCntWidth-1:0]      count_o,
  output logic                        is_empty_o
);

  // Word under work
  op_e                   op_q;
  logic [ValueWidth-1:0] value_q;

  // Set state and walk pointers
  logic [CntWidth-1:0]   count_q, count_d;
  logic [CntWidth-1:0]   idx_q, idx_d;
  logic [AddrWidth-1:0]  cmp_idx_q, cmp_idx_d;
  logic                  pend_q, pend_d;
  logic                  hit_q, hit_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic                  found_q;
  status_e               status_q, status_d;
  logic [CntWidth-1:0]   ocount_q;

  // RAM port
  logic                  we;
  logic [AddrWidth-1:0]  waddr;
  logic [ValueWidth-1:0] wdata;
  logic [ValueWidth-1:0] rdata;

  logic match;
  logic more;
  logic full;
  logic out_free;

  assign match    = pend_q && (rdata == value_q);
  assign more     = idx_q < count_q;
  assign full     = count_q == CntWidth'(Capacity);
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.search_done = match || !more;
  assign sts_o.match       = match;
  assign sts_o.shift_done  = !more && !pend_q;
  assign sts_o.out_free    = out_free;
  assign sts_o.is_remove   = op_q == OP_REMOVE;

  bcs_ram #(
    .Width (ValueWidth),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_q[AddrWidth-1:0]),
    .rdata_o (rdata)
  );

  // Pointer, count and RAM write control
  always_comb begin
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    pend_d    = pend_q;
    hit_d     = hit_q;
    count_d   = count_q;
    status_d  = ST_OK;
    we        = 1'b0;
    waddr     = cmp_idx_q;
    wdata     = rdata;

    if (cmd_i.load) begin
      idx_d  = '0;
      pend_d = 1'b0;
    end

    // linear search: issue next read unless the pending compare hit or all entries were read
    if (cmd_i.search) begin
      if (!match && more) begin
        pend_d    = 1'b1;
        cmp_idx_d = idx_q[AddrWidth-1:0];
        idx_d     = idx_q + 1'b1;
      end else begin
        pend_d = 1'b0;
      end
      if (sts_o.search_done) begin
        hit_d = match;
      end
    end

    if (cmd_i.shift_init) begin
      idx_d  = CntWidth'(cmp_idx_q) + 1'b1;
      pend_d = 1'b0;
    end

    // shift-down: write data read last cycle one slot lower
    if (cmd_i.shift) begin
      we = pend_q;
      if (more) begin
        pend_d    = 1'b1;
        cmp_idx_d = AddrWidth'(idx_q - 1'b1);
        idx_d     = idx_q + 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end

    if (cmd_i.finish) begin
      case (op_q)
        OP_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = count_q[AddrWidth-1:0];
            wdata   = value_q;
            count_d = count_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else if (!hit_q) begin
            status_d = ST_MISSING;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        OP_QUERY: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else if (!hit_q) begin
            status_d = ST_MISSING;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // Output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    if (cmd_i.load) begin
      op_q    <= op_e'(func_i);
      value_q <= ValueWidth'(value_i);
    end
    if (cmd_i.finish) begin
      found_q  <= (op_q == OP_CLEAR) ? 1'b0 : hit_q;
      status_q <= status_d;
      ocount_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign status_o    = status_q;
  assign count_o     = OutCntWidth'(ocount_q);
  assign is_empty_o  = ocount_q == '0;

  // Fill count never exceeds the array
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(Capacity))
    else $error("fill count above capacity");

  // Pending read or shift write always targets a stored entry
  a_pend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (CntWidth'(cmp_idx_q) < count_q))
    else $error("pending access outside stored entries");

  // A result is only produced into a free output register
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> out_free)
    else $error("result overwrote an unread word");

  // A result appears in the cycle after finish
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("result not presented after finish");

endmodule

`default_nettype wire

### hw/rtl/bounded_compacting_set.sv
// Bounded compacting set: one result word per input word, one word in flight at a time.
// Clear goes straight to the result; insert, query and remove first search the entry RAM, and a
// remove hit then compacts it. The time per word is set by the one-read-per-cycle walk over
// the entry RAM (search up to the match, then shift-down over the entries above it), plus
// output stalls.
// Reset clears fill count and control, not the entry RAM. Uses bcs_pkg, bcs_ctrl, bcs_datapath.
`default_nettype none

module bounded_compacting_set import bcs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [FuncWidth-1:0]   func_i,
  input  wire logic [InValWidth-1:0]  value_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        found_o,
  output logic [StatWidth-1:0]        status_o,
  output logic [OutCntWidth-1:0]      count_o,
  output logic                        is_empty_o
);

  cmd_t cmd;
  sts_t sts;

  bcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bcs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o)
  );

endmodule

`default_nettype wire
